// File: design/pt_walk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pt_walk_pkg
// Types, constants and the microcode table of the four-level page table
// walker.
// ----------------------------------------------------------------------------
package pt_walk_pkg;

  localparam int ENTRIES   = 512;
  localparam int IDX_W     = 9;
  localparam int PA_W      = 52;
  localparam int PAGE_W    = 40;

  localparam int PTE_PRESENT_BIT = 0;
  localparam int PTE_HUGE_BIT    = 7;

  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  // va slice used for the next table index
  localparam logic [1:0] IX_L3 = 2'd0;  // va[38:30]
  localparam logic [1:0] IX_L2 = 2'd1;  // va[29:21]
  localparam logic [1:0] IX_L1 = 2'd2;  // va[20:12]

  localparam logic KIND_WRITE = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [51:0] entry_addr;
    logic [63:0] entry_value;
    logic [63:0] vaddr;
  } in_req_t;

  typedef struct packed {
    logic        mapped;
    logic [51:0] paddr;
    logic [1:0]  page_size;
    logic        out_of_range;
  } out_rsp_t;

  typedef enum logic [1:0] {
    OP_CLR,
    OP_IDLE,
    OP_EVAL,
    OP_FIN
  } op_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_E4,
    ST_E3,
    ST_E2,
    ST_E1,
    ST_FIN
  } step_t;

  typedef struct packed {
    op_t        op;
    logic       huge_ok;
    logic       last;
    logic [1:0] size;
    logic [1:0] idx_sel;
    step_t      nxt;
  } ctrl_word_t;

  localparam ctrl_word_t UCODE [8] = '{
    '{op: OP_CLR,  huge_ok: 1'b0, last: 1'b0, size: PS_4K, idx_sel: IX_L3, nxt: ST_IDLE},
    '{op: OP_IDLE, huge_ok: 1'b0, last: 1'b0, size: PS_4K, idx_sel: IX_L3, nxt: ST_E4},
    '{op: OP_EVAL, huge_ok: 1'b0, last: 1'b0, size: PS_4K, idx_sel: IX_L3, nxt: ST_E3},
    '{op: OP_EVAL, huge_ok: 1'b1, last: 1'b0, size: PS_1G, idx_sel: IX_L2, nxt: ST_E2},
    '{op: OP_EVAL, huge_ok: 1'b1, last: 1'b0, size: PS_2M, idx_sel: IX_L1, nxt: ST_E1},
    '{op: OP_EVAL, huge_ok: 1'b0, last: 1'b1, size: PS_4K, idx_sel: IX_L1, nxt: ST_FIN},
    '{op: OP_FIN,  huge_ok: 1'b0, last: 1'b0, size: PS_4K, idx_sel: IX_L3, nxt: ST_IDLE},
    '{op: OP_FIN,  huge_ok: 1'b0, last: 1'b0, size: PS_4K, idx_sel: IX_L3, nxt: ST_IDLE}
  };

endpackage

// File: design/four_level_page_table_walker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// Four-level page table walker over an on-chip table memory, sequenced by a
// small microcode table. Write requests store one entry; translate requests
// walk the tables from the root register.
// Steps: a write, or a translate with the root outside memory, goes from accept
//   to the result step ST_FIN; other translates do one dependent read of the
//   single-port table memory per level (ST_E4 to ST_E1) before ST_FIN.
// A new request is taken only in ST_IDLE, once ST_FIN has passed on the last result.
// Reset: a clearing pass zeroes the table memory with in_ready low; cfg
//   writes are taken throughout.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top #(
  parameter int TABLE_PAGES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [51:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pt_walk_pkg::in_req_t   in_req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pt_walk_pkg::out_rsp_t  out_rsp
);

  localparam int PG_W  = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int AW    = PG_W + pt_walk_pkg::IDX_W;
  localparam int DEPTH = TABLE_PAGES * pt_walk_pkg::ENTRIES;

  pt_walk_pkg::step_t      step_r, step_nxt;
  pt_walk_pkg::ctrl_word_t cw;

  logic [39:0]             root_page_r;
  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic [47:0]             va_r, va_nxt;
  logic [63:0]             rdata_r;
  pt_walk_pkg::out_rsp_t   res_r, res_nxt;
  pt_walk_pkg::out_rsp_t   out_rsp_r;
  logic                    out_valid_r;

  logic [63:0]             mem [DEPTH];
  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_addr;
  logic [63:0]             mem_wdata;

  logic                    in_fire, out_load;
  logic                    wr_ok, root_ok, next_ok;
  logic                    ent_present, take_huge;
  logic [39:0]             next_page;
  logic [8:0]              next_idx;

  assign cw          = pt_walk_pkg::UCODE[step_r];
  assign cfg_ready   = 1'b1;
  assign in_ready    = (cw.op == pt_walk_pkg::OP_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_rsp     = out_rsp_r;
  assign out_load    = (cw.op == pt_walk_pkg::OP_FIN) && (!out_valid_r || out_ready);

  assign wr_ok       = in_req.entry_addr[51:12] < 40'(TABLE_PAGES);
  assign root_ok     = root_page_r < 40'(TABLE_PAGES);
  assign ent_present = rdata_r[pt_walk_pkg::PTE_PRESENT_BIT];
  assign take_huge   = cw.huge_ok && rdata_r[pt_walk_pkg::PTE_HUGE_BIT];
  assign next_page   = rdata_r[51:12];
  assign next_ok     = next_page < 40'(TABLE_PAGES);

  always_comb begin
    case (cw.idx_sel)
      pt_walk_pkg::IX_L3: next_idx = va_r[38:30];
      pt_walk_pkg::IX_L2: next_idx = va_r[29:21];
      default:            next_idx = va_r[20:12];
    endcase
  end

  // next step
  always_comb begin
    step_nxt = step_r;
    unique case (cw.op)
      pt_walk_pkg::OP_CLR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) step_nxt = cw.nxt;
      end
      pt_walk_pkg::OP_IDLE: begin
        if (in_fire) begin
          if (in_req.kind == pt_walk_pkg::KIND_WRITE || !root_ok) step_nxt = pt_walk_pkg::ST_FIN;
          else step_nxt = cw.nxt;
        end
      end
      pt_walk_pkg::OP_EVAL: begin
        if (!ent_present || take_huge || cw.last || !next_ok) step_nxt = pt_walk_pkg::ST_FIN;
        else step_nxt = cw.nxt;
      end
      pt_walk_pkg::OP_FIN: begin
        if (out_load) step_nxt = cw.nxt;
      end
      default: step_nxt = pt_walk_pkg::ST_CLR;
    endcase
  end

  // datapath control
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = '0;
    mem_wdata   = in_req.entry_value;
    clr_cnt_nxt = clr_cnt_r;
    va_nxt      = va_r;
    res_nxt     = res_r;
    unique case (cw.op)
      pt_walk_pkg::OP_CLR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      pt_walk_pkg::OP_IDLE: begin
        if (in_fire) begin
          res_nxt = '0;
          if (in_req.kind == pt_walk_pkg::KIND_WRITE) begin
            mem_we               = wr_ok;
            mem_addr             = in_req.entry_addr[AW+2:3];
            res_nxt.out_of_range = !wr_ok;
          end else begin
            va_nxt               = in_req.vaddr[47:0];
            mem_re               = root_ok;
            mem_addr             = {root_page_r[PG_W-1:0], in_req.vaddr[47:39]};
            res_nxt.out_of_range = !root_ok;
          end
        end
      end
      pt_walk_pkg::OP_EVAL: begin
        res_nxt = '0;
        if (ent_present) begin
          if (take_huge) begin
            res_nxt.mapped    = 1'b1;
            res_nxt.page_size = cw.size;
            if (cw.size == pt_walk_pkg::PS_1G) res_nxt.paddr = {rdata_r[51:30], va_r[29:0]};
            else res_nxt.paddr = {rdata_r[51:21], va_r[20:0]};
          end else if (cw.last) begin
            res_nxt.mapped    = 1'b1;
            res_nxt.page_size = pt_walk_pkg::PS_4K;
            res_nxt.paddr     = {rdata_r[51:12], va_r[11:0]};
          end else if (next_ok) begin
            mem_re   = 1'b1;
            mem_addr = {next_page[PG_W-1:0], next_idx};
          end else begin
            res_nxt.out_of_range = 1'b1;
          end
        end
      end
      pt_walk_pkg::OP_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= pt_walk_pkg::ST_CLR;
      clr_cnt_r   <= '0;
      root_page_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_valid && cfg_ready) root_page_r <= cfg_data[51:12];
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    va_r  <= va_nxt;
    res_r <= res_nxt;
    if (out_load) out_rsp_r <= res_r;
  end

  // table memory, single port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_addr];
  end

endmodule
